### rtl/bam_pkg.sv
`default_nettype none

package bam_pkg;

    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // '['
    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // '('
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // '{'
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ']'
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // ')'
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // '}'

    typedef enum logic [1:0] {
        CODE_SQUARE = 2'd0,
        CODE_ROUND  = 2'd1,
        CODE_CURLY  = 2'd2,
        CODE_SPARE  = 2'd3
    } bam_code_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EXTRA    = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_OVERFLOW = 2'd3
    } bam_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // a character request is taken this cycle
        logic check;       // compare the popped entry with the closer
        logic out_status;  // load the status result
        logic rd_drain;    // pop one entry for the end-of-string run
        logic out_closer;  // load one closer result
        logic clear;       // empty the stack and drop the error
    } bam_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_go;      // the offered character will pop an entry
        logic out_free;    // the result register can take a new result
        logic finish;      // the status result is the final one
        logic stack_empty; // no entries left on the stack
    } bam_stat_t;

    function automatic logic [7:0] closer_char(input bam_code_t code);
        logic [7:0] c;
        case (code)
            CODE_ROUND: c = CH_CLOSE_ROUND;
            CODE_CURLY: c = CH_CLOSE_CURLY;
            default:    c = CH_CLOSE_SQUARE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/bam_ctrl.sv
`default_nettype none

module bam_ctrl
    import bam_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_last,
    output logic           s_ready,
    input  wire bam_stat_t stat,
    output bam_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_CHECK    = 5'b00010,
        S_STATUS   = 5'b00100,
        S_DRAIN_RD = 5'b01000,
        S_DRAIN_WR = 5'b10000
    } bam_state_t;

    bam_state_t state_reg, state_next;
    logic       last_pend_reg, last_pend_next;

    always_comb begin
        state_next     = state_reg;
        last_pend_next = last_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept     = 1'b1;
                    last_pend_next = s_last;
                    if (stat.pop_go) begin
                        state_next = S_CHECK;
                    end else if (s_last) begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = last_pend_reg ? S_STATUS : S_IDLE;
            end
            S_STATUS: begin
                if (stat.out_free) begin
                    cmd.out_status = 1'b1;
                    if (stat.finish) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            S_DRAIN_RD: begin
                cmd.rd_drain = 1'b1;
                state_next   = S_DRAIN_WR;
            end
            S_DRAIN_WR: begin
                if (stat.out_free) begin
                    cmd.out_closer = 1'b1;
                    if (stat.stack_empty) begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            last_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_pend_reg <= last_pend_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bam_dp.sv
`default_nettype none

module bam_dp
    import bam_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_ch,
    input  wire bam_cmd_t   cmd,
    output bam_stat_t       stat,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_append_char,
    output logic            m_char_valid,
    output logic [1:0]      m_status,
    output logic            m_last_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    bam_code_t   stack_mem [STACK_DEPTH];
    bam_code_t   rd_data_reg;
    bam_code_t   want_reg, want_next;

    logic [CW-1:0] count_reg, count_next;
    bam_status_t   err_reg, err_next;

    logic [CW-1:0] count_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic          wr_en;

    logic          is_open;
    logic          is_close;
    bam_code_t     ch_code;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    append_reg;
    logic          char_valid_reg;
    bam_status_t   status_reg;
    logic          last_out_reg;

    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        ch_code  = CODE_SQUARE;
        unique case (s_ch)
            CH_OPEN_SQUARE:  begin is_open  = 1'b1; ch_code = CODE_SQUARE; end
            CH_OPEN_ROUND:   begin is_open  = 1'b1; ch_code = CODE_ROUND;  end
            CH_OPEN_CURLY:   begin is_open  = 1'b1; ch_code = CODE_CURLY;  end
            CH_CLOSE_SQUARE: begin is_close = 1'b1; ch_code = CODE_SQUARE; end
            CH_CLOSE_ROUND:  begin is_close = 1'b1; ch_code = CODE_ROUND;  end
            CH_CLOSE_CURLY:  begin is_close = 1'b1; ch_code = CODE_CURLY;  end
            default: ;
        endcase
    end

    assign count_dec = count_reg - ONE;
    assign rd_addr   = count_dec[AW-1:0];
    assign wr_addr   = count_reg[AW-1:0];

    assign stat.pop_go      = is_close && (err_reg == ST_OK) && (count_reg != '0);
    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.finish      = (err_reg != ST_OK) || (count_reg == '0);
    assign stat.stack_empty = (count_reg == '0);

    // Every pop reads the entry just below the current count.
    assign rd_en = (cmd.accept && stat.pop_go) || cmd.rd_drain;
    assign wr_en = cmd.accept && is_open && (err_reg == ST_OK) && (count_reg != FULL);

    always_comb begin
        count_next = count_reg;
        err_next   = err_reg;
        want_next  = want_reg;
        if (cmd.accept && (err_reg == ST_OK)) begin
            if (is_open) begin
                if (count_reg == FULL) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + ONE;
                end
            end else if (is_close) begin
                if (count_reg == '0) begin
                    err_next = ST_EXTRA;
                end else begin
                    count_next = count_dec;
                    want_next  = ch_code;
                end
            end
        end
        if (cmd.check && (rd_data_reg != want_reg)) begin
            err_next = ST_MISMATCH;
        end
        if (cmd.rd_drain) begin
            count_next = count_dec;
        end
        if (cmd.clear) begin
            count_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= ch_code;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_status || cmd.out_closer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_status) begin
            append_reg     <= 8'h00;
            char_valid_reg <= 1'b0;
            status_reg     <= stat.finish ? err_reg : ST_OK;
            last_out_reg   <= stat.finish;
        end else if (cmd.out_closer) begin
            append_reg     <= closer_char(rd_data_reg);
            char_valid_reg <= 1'b1;
            status_reg     <= ST_OK;
            last_out_reg   <= stat.stack_empty;
        end
        want_reg <= want_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_append_char = append_reg;
    assign m_char_valid  = char_valid_reg;
    assign m_status      = status_reg;
    assign m_last_out    = last_out_reg;

endmodule

`default_nettype wire

### rtl/bracket_autoclose_matcher.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_ch[7:0], s_last
// m_        out        m_valid / m_ready  m_append_char[7:0], m_char_valid,
//                                         m_status[1:0], m_last_out
//
// A character is taken in S_IDLE; a closer that pops a stack entry also passes
// through S_CHECK, as the popped entry comes out of the registered read port of
// the stack. The end of a string adds the status result, then, if no error is
// latched, a read and a load of the result register per stacked closer, and it
// waits while m_ready is low. Reset is synchronous: the stack count and the
// error are cleared; the stack memory itself is not swept.

module bracket_autoclose_matcher
    import bam_pkg::*;
#(
    parameter int STACK_DEPTH = 32
)(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_append_char,
    output logic            m_char_valid,
    output logic [1:0]      m_status,
    output logic            m_last_out
);

    bam_cmd_t  cmd;
    bam_stat_t stat;

    bam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bam_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_ch          (s_ch),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_append_char (m_append_char),
        .m_char_valid  (m_char_valid),
        .m_status      (m_status),
        .m_last_out    (m_last_out)
    );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bam_pkg::*;

    localparam int MODEL_DEPTH = 32;
    localparam int LONG_HOLD = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 135;
    localparam int SHOWN_MISMATCHES = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_req_t;

    typedef struct packed {
        logic [7:0] append_char;
        logic       char_valid;
        logic [1:0] status;
        logic       last_out;
    } close_result_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'h00;
    logic       s_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_append_char;
    logic       m_char_valid;
    logic [1:0] m_status;
    logic       m_last_out;

    char_req_t     char_q[$];
    close_result_t awaited_q[$];
    char_req_t     next_req;
    logic          s_taken = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int queued_items = 0;

    // Predictor state: stacked closer codes, depth and the latched error.
    bam_code_t   model_stack[MODEL_DEPTH];
    int          model_depth = 0;
    bam_status_t model_err = ST_OK;

    bracket_autoclose_matcher DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_append_char (m_append_char),
        .m_char_valid  (m_char_valid),
        .m_status      (m_status),
        .m_last_out    (m_last_out)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] closer_of(input bam_code_t code);
        logic [7:0] c;
        case (code)
            CODE_ROUND: c = CH_CLOSE_ROUND;
            CODE_CURLY: c = CH_CLOSE_CURLY;
            default:    c = CH_CLOSE_SQUARE;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] opener_of(input bam_code_t code);
        logic [7:0] c;
        case (code)
            CODE_ROUND: c = CH_OPEN_ROUND;
            CODE_CURLY: c = CH_OPEN_CURLY;
            default:    c = CH_OPEN_SQUARE;
        endcase
        return c;
    endfunction

    task automatic track_char(input logic [7:0] ch, input logic fin);
        logic      opens;
        logic      closes;
        bam_code_t code;
        opens = 1'b0;
        closes = 1'b0;
        code = CODE_SQUARE;
        case (ch)
            CH_OPEN_SQUARE:  begin opens = 1'b1;  code = CODE_SQUARE; end
            CH_OPEN_ROUND:   begin opens = 1'b1;  code = CODE_ROUND;  end
            CH_OPEN_CURLY:   begin opens = 1'b1;  code = CODE_CURLY;  end
            CH_CLOSE_SQUARE: begin closes = 1'b1; code = CODE_SQUARE; end
            CH_CLOSE_ROUND:  begin closes = 1'b1; code = CODE_ROUND;  end
            CH_CLOSE_CURLY:  begin closes = 1'b1; code = CODE_CURLY;  end
            default: ;
        endcase
        if (model_err == ST_OK) begin
            if (opens) begin
                if (model_depth >= MODEL_DEPTH) begin
                    model_err = ST_OVERFLOW;
                end else begin
                    model_stack[model_depth] = code;
                    model_depth++;
                end
            end else if (closes) begin
                if (model_depth == 0) begin
                    model_err = ST_EXTRA;
                end else begin
                    // A mismatching entry stays popped.
                    model_depth--;
                    if (model_stack[model_depth] != code)
                        model_err = ST_MISMATCH;
                end
            end
        end
        if (fin) begin
            if (model_err != ST_OK || model_depth == 0) begin
                awaited_q.push_back('{append_char: 8'h00, char_valid: 1'b0,
                                      status: model_err, last_out: 1'b1});
            end else begin
                awaited_q.push_back('{append_char: 8'h00, char_valid: 1'b0,
                                      status: ST_OK, last_out: 1'b0});
                while (model_depth > 0) begin
                    model_depth--;
                    awaited_q.push_back('{append_char: closer_of(model_stack[model_depth]),
                                          char_valid: 1'b1, status: ST_OK,
                                          last_out: (model_depth == 0)});
                end
            end
            model_depth = 0;
            model_err = ST_OK;
        end
    endtask

    task automatic check_result();
        close_result_t got;
        close_result_t want;
        got = '{append_char: m_append_char, char_valid: m_char_valid,
                status: m_status, last_out: m_last_out};
        if (awaited_q.size() == 0) begin
            if (mismatches < SHOWN_MISMATCHES)
                $display("unexpected result at %0t: char %h valid %b status %0d last %b",
                         $realtime, got.append_char, got.char_valid, got.status,
                         got.last_out);
            mismatches++;
        end else begin
            want = awaited_q.pop_front();
            if (got !== want) begin
                if (mismatches < SHOWN_MISMATCHES)
                    $display("mismatch at %0t: expected %h %b %0d %b, got %h %b %0d %b",
                             $realtime, want.append_char, want.char_valid, want.status,
                             want.last_out, got.append_char, got.char_valid, got.status,
                             got.last_out);
                mismatches++;
            end
        end
    endtask

    // Sampling side: requests go to the predictor, results to the checker.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            track_char(s_ch, s_last);
        if (aresetn && m_valid && m_ready)
            check_result();
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_ch <= 8'h00;
            s_last <= 1'b0;
        end else if (s_valid && !s_taken) begin
            // The request is still waiting; keep it as it is.
        end else if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = char_q.pop_front();
            s_valid <= 1'b1;
            s_ch <= next_req.ch;
            s_last <= next_req.last;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic put_char(input logic [7:0] ch, input logic fin);
        char_q.push_back('{ch: ch, last: fin});
        queued_items++;
    endtask

    task automatic push_text(input logic [7:0] txt[$]);
        foreach (txt[i])
            put_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i], i == s.len() - 1);
    endtask

    // Nested brackets with letters between them; a broken string gets one
    // stray closer somewhere.
    task automatic gen_nested(input int max_len, input logic broken);
        logic [7:0] txt[$];
        bam_code_t  open_q[$];
        bam_code_t  c;
        int         len;
        int         pick;
        len = $urandom_range(1, max_len);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                c = bam_code_t'($urandom_range(0, 2));
                open_q.push_back(c);
                txt.push_back(opener_of(c));
            end else if (pick < 7 && open_q.size() > 0) begin
                c = open_q.pop_back();
                txt.push_back(closer_of(c));
            end else begin
                txt.push_back(8'($urandom_range(97, 122)));
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            while (open_q.size() > 0)
                txt.push_back(closer_of(open_q.pop_back()));
        end
        if (broken)
            txt.insert($urandom_range(0, txt.size()),
                       closer_of(bam_code_t'($urandom_range(0, 2))));
        push_text(txt);
    endtask

    // Runs of openers around the stack depth: full stacks and overflows.
    task automatic gen_deep();
        logic [7:0] txt[$];
        int         n;
        n = $urandom_range(MODEL_DEPTH - 4, MODEL_DEPTH + 2);
        for (int k = 0; k < n; k++)
            txt.push_back(opener_of(bam_code_t'($urandom_range(0, 2))));
        if ($urandom_range(0, 2) == 0)
            txt.push_back(8'($urandom_range(0, 255)));
        push_text(txt);
    endtask

    task automatic gen_noise();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
            put_char(8'($urandom_range(0, 255)), k == len - 1);
    endtask

    task automatic gen_any();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gen_nested(14, 1'b0);
        else if (pick < 70)
            gen_nested(10, 1'b1);
        else if (pick < 84)
            gen_noise();
        else if (pick < 92)
            gen_deep();
        else
            put_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic fill_phase();
        int target;
        target = queued_items + PHASE_ITEMS;
        while (queued_items < target)
            gen_any();
    endtask

    task automatic wait_drained();
        while (char_q.size() > 0 || s_valid || awaited_q.size() > 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 47;
        push_str("a");
        push_str("[");
        push_str("([{");
        push_str(")");
        push_str("(]");
        push_str("()");
        push_str("])}");
        push_str("{x}(");
        put_char(8'h00, 1'b1);
        put_char(8'hFF, 1'b1);
        push_str("(}[");
        push_str("[]]");
        wait_drained();

        fill_phase();
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 29;
        fill_phase();
        wait_drained();

        // The receiver holds off while deep strings keep coming, so the
        // block backs up and stops taking requests.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        gen_deep();
        gen_deep();
        fill_phase();
        wait_drained();

        repeat (8) @(posedge aclk);
        mismatches += awaited_q.size();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
